// ===== design/per_cpu_page_allocator_assert.svh =====
// Assertion macros used by the top-level file of this block.
`ifndef PER_CPU_PAGE_ALLOCATOR_ASSERT_SVH
`define PER_CPU_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PCPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PCPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pcpa_pkg.sv =====
package pcpa_pkg;

  // Sizing of the managed area.
  localparam int NUM_PAGES  = 32768;
  localparam int NUM_CPUS   = 8;
  localparam int PAGE_BYTES = 4096;

  // Field widths.
  localparam int ADDR_W     = 56;
  localparam int ACTION_W   = 2;
  localparam int CPU_IN_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;

  // Derived widths.
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PN_W       = ADDR_W - PAGE_SHIFT + 1;
  localparam int PG_W       = $clog2(NUM_PAGES);
  localparam int LINK_W     = $clog2(NUM_PAGES + 1);
  localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // Command queue between the classifier and the executor.
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOP  = CFG_IDX_W'(1);

  // Register reset values.
  localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(64'h0000_0000_8000_0000);
  localparam logic [ADDR_W-1:0] TOP_RESET  = ADDR_W'(64'h0000_0000_8800_0000);
  localparam logic [PN_W-1:0]   PB_RESET   =
    PN_W'((64'(BASE_RESET) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT);

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD = 2'd2;

  // Command kinds after classification.
  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_INIT  = 3'd2;
  localparam logic [2:0] CMD_NOP   = 3'd3;
  localparam logic [2:0] CMD_BAD   = 3'd4;

  // One classified request.
  typedef struct packed {
    logic [2:0]        kind;
    logic [CPU_W-1:0]  cpu;
    logic [PG_W-1:0]   idx;
    logic [LINK_W-1:0] npg;
    logic [PN_W-1:0]   pb_pg;
  } cmd_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Executor status.
  typedef struct packed {
    logic idle;
    logic in_init;
  } bstat_t;

endpackage

// ===== design/pcpa_front.sv =====
module pcpa_front import pcpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [CPU_IN_W-1:0]  in_cpu,
  input  logic [ADDR_W-1:0]    in_page_addr,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  qstat_t               qstat,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] top_r, top_nxt;
  logic [PN_W-1:0]   pb_pg_r, pb_pg_nxt;

  logic [ADDR_W:0]   pb_addr;
  logic              top_gt;
  logic [PN_W-1:0]   top_diff;
  logic [LINK_W-1:0] npg;
  logic [PN_W-1:0]   pa_diff;
  logic              bad;

  // Configuration writes are always taken; the rounded base page is kept with them.
  assign cfg_ready = 1'b1;

  always_comb begin
    base_nxt  = base_r;
    top_nxt   = top_r;
    pb_pg_nxt = pb_pg_r;
    if (cfg_valid) begin
      if (cfg_index == REG_BASE) begin
        base_nxt  = cfg_data;
        pb_pg_nxt = {1'b0, cfg_data[ADDR_W-1:PAGE_SHIFT]}
                    + PN_W'(|cfg_data[PAGE_SHIFT-1:0]);
      end else if (cfg_index == REG_TOP) begin
        top_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      top_r   <= TOP_RESET;
      pb_pg_r <= PB_RESET;
    end else begin
      base_r  <= base_nxt;
      top_r   <= top_nxt;
      pb_pg_r <= pb_pg_nxt;
    end
  end

  // Page count for initialize, capped at the size of the link memory.
  assign pb_addr  = {pb_pg_r, {PAGE_SHIFT{1'b0}}};
  assign top_gt   = {1'b0, top_r} > pb_addr;
  assign top_diff = {1'b0, top_r[ADDR_W-1:PAGE_SHIFT]} - pb_pg_r;

  always_comb begin
    if (!top_gt) begin
      npg = '0;
    end else if (top_diff > PN_W'(NUM_PAGES)) begin
      npg = LINK_W'(NUM_PAGES);
    end else begin
      npg = top_diff[LINK_W-1:0];
    end
  end

  // Free address check: alignment, register bounds and page count.
  // The page offset is only meaningful once the address is at or above the base.
  assign pa_diff = {1'b0, in_page_addr[ADDR_W-1:PAGE_SHIFT]} - pb_pg_r;
  assign bad = (|in_page_addr[PAGE_SHIFT-1:0])
               || (in_page_addr < base_r)
               || (in_page_addr >= top_r)
               || ({1'b0, in_page_addr} < pb_addr)
               || (pa_diff >= PN_W'(NUM_PAGES));

  // A request enters the queue whenever the queue has room.
  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.cpu   = CPU_W'(in_cpu % NUM_CPUS);
    push_cmd.idx   = pa_diff[PG_W-1:0];
    push_cmd.npg   = npg;
    push_cmd.pb_pg = pb_pg_r;
    unique case (in_action)
      ACT_ALLOC: push_cmd.kind = CMD_ALLOC;
      ACT_FREE:  push_cmd.kind = bad ? CMD_BAD : CMD_FREE;
      ACT_INIT:  push_cmd.kind = CMD_INIT;
      default:   push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== design/pcpa_queue.sv =====
module pcpa_queue import pcpa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   pop_cmd,
  output qstat_t qstat
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_cmd     = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/pcpa_back.sv =====
module pcpa_back import pcpa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  qstat_t              qstat,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   out_alloc_addr,
  output logic [STATUS_W-1:0] out_status,
  output bstat_t              bstat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_INIT  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [LINK_W-1:0]   head_r [NUM_CPUS];
  logic [LINK_W-1:0]   head_nxt [NUM_CPUS];

  logic [CPU_W-1:0]    v_r, v_nxt;
  logic [LINK_W-1:0]   h_r, h_nxt;
  logic [PN_W-1:0]     apb_r, apb_nxt;

  logic [LINK_W-1:0]   ini_pg_r, ini_pg_nxt;
  logic [LINK_W-1:0]   ini_k_r, ini_k_nxt;
  logic [LINK_W-1:0]   ini_size_r, ini_size_nxt;
  logic [LINK_W-1:0]   ini_q_r, ini_q_nxt;
  logic [CPU_W-1:0]    ini_cpu_r, ini_cpu_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [LINK_W-1:0]   link_mem [NUM_PAGES];
  logic [LINK_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [PG_W-1:0]     mem_waddr;
  logic [LINK_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [PG_W-1:0]     mem_raddr;

  logic [NUM_CPUS-1:0] nz;
  logic [CPU_W-1:0]    low_idx;
  logic [CPU_W-1:0]    victim;
  logic [CPU_W-1:0]    sel_cpu;
  logic [LINK_W-1:0]   sel_head;
  logic                start;
  logic [PN_W-1:0]     page_sum;
  logic [LINK_W-1:0]   ini_k1;
  logic                ini_last;

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_status_r;
  assign bstat.idle     = (state_r == S_IDLE);
  assign bstat.in_init  = (state_r == S_INIT);

  // A command starts only when the result slot is free by the end of this cycle.
  assign start = (state_r == S_IDLE) && !qstat.empty && (!out_valid_r || out_ready);
  assign q_pop = start;

  // Victim list for allocate: own list first, else the lowest non-empty one.
  always_comb begin
    low_idx = '0;
    for (int c = NUM_CPUS - 1; c >= 0; c--) begin
      nz[c] = (head_r[c] != '0);
      if (head_r[c] != '0) begin
        low_idx = CPU_W'(c);
      end
    end
  end

  assign victim   = nz[q_cmd.cpu] ? q_cmd.cpu : low_idx;
  assign sel_cpu  = (q_cmd.kind == CMD_FREE) ? q_cmd.cpu : victim;
  assign sel_head = head_r[sel_cpu];

  // Address of the popped page and position inside the current init share.
  assign page_sum = apb_r + PN_W'(h_r - LINK_W'(1));
  assign ini_k1   = ini_k_r + LINK_W'(1);
  assign ini_last = (ini_k1 == ini_size_r);

  // Sequencer for the command flows: allocate, free, initialize, bad free and unknown.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    v_nxt          = v_r;
    h_nxt          = h_r;
    apb_nxt        = apb_r;
    ini_pg_nxt     = ini_pg_r;
    ini_k_nxt      = ini_k_r;
    ini_size_nxt   = ini_size_r;
    ini_q_nxt      = ini_q_r;
    ini_cpu_nxt    = ini_cpu_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (q_cmd.kind)
            CMD_ALLOC: begin
              if (nz == '0) begin
                out_valid_nxt  = 1'b1;
                out_addr_nxt   = '0;
                out_status_nxt = STAT_OOM;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = PG_W'(sel_head - LINK_W'(1));
                v_nxt     = victim;
                h_nxt     = sel_head;
                apb_nxt   = q_cmd.pb_pg;
                state_nxt = S_ALLOC;
              end
            end
            CMD_FREE: begin
              mem_we                = 1'b1;
              mem_waddr             = q_cmd.idx;
              mem_wdata             = sel_head;
              head_nxt[q_cmd.cpu]   = LINK_W'(q_cmd.idx) + LINK_W'(1);
              out_valid_nxt         = 1'b1;
              out_addr_nxt          = '0;
              out_status_nxt        = STAT_OK;
            end
            CMD_BAD: begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = STAT_BAD;
            end
            CMD_INIT: begin
              for (int c = 0; c < NUM_CPUS; c++) begin
                head_nxt[c] = '0;
              end
              ini_pg_nxt   = q_cmd.npg;
              ini_k_nxt    = '0;
              ini_cpu_nxt  = '0;
              ini_q_nxt    = LINK_W'(q_cmd.npg / NUM_CPUS);
              ini_size_nxt = LINK_W'(q_cmd.npg / NUM_CPUS) + LINK_W'(q_cmd.npg % NUM_CPUS);
              state_nxt    = S_INIT;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // The read link becomes the new head of the victim list.
        head_nxt[v_r]  = rd_data_r;
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = {page_sum[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
        out_status_nxt = STAT_OK;
        state_nxt      = S_IDLE;
      end
      S_INIT: begin
        if (ini_pg_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
        end else begin
          // Link one page per cycle, walking down from the top page.
          mem_we    = 1'b1;
          mem_waddr = PG_W'(ini_pg_r - LINK_W'(1));
          mem_wdata = ini_last ? '0 : (ini_pg_r - LINK_W'(1));
          if (ini_k_r == '0) begin
            head_nxt[ini_cpu_r] = ini_pg_r;
          end
          if (ini_last) begin
            ini_k_nxt    = '0;
            ini_cpu_nxt  = ini_cpu_r + CPU_W'(1);
            ini_size_nxt = ini_q_r;
          end else begin
            ini_k_nxt = ini_k1;
          end
          ini_pg_nxt = ini_pg_r - LINK_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CPUS; c++) begin
        head_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    h_r          <= h_nxt;
    apb_r        <= apb_nxt;
    ini_pg_r     <= ini_pg_nxt;
    ini_k_r      <= ini_k_nxt;
    ini_size_r   <= ini_size_nxt;
    ini_q_r      <= ini_q_nxt;
    ini_cpu_r    <= ini_cpu_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // Next-link memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[mem_raddr];
    end
  end

endmodule

// ===== design/per_cpu_page_allocator.sv =====
// Free, bad free, unknown and out-of-memory requests give a registered result from the idle executor;
// allocate first reads the next-link memory, and initialize links all of its pages before its result.
// Requests enter at one per cycle into a 2-entry queue while it has room; the executor takes
// a new request only when idle and when its result register is free or being taken.
// Reset (synchronous, active low) empties all lists and the queue; the link memory is not cleared.
`include "per_cpu_page_allocator_assert.svh"
module per_cpu_page_allocator import pcpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [CPU_IN_W-1:0]  in_cpu,
  input  logic [ADDR_W-1:0]    in_page_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_alloc_addr,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  qstat_t qstat;
  bstat_t bstat;
  logic   q_push;
  logic   q_pop;
  cmd_t   push_cmd;
  cmd_t   pop_cmd;

  // Request classification and configuration registers.
  pcpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_cpu       (in_cpu),
    .in_page_addr (in_page_addr),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .qstat        (qstat),
    .push         (q_push),
    .push_cmd     (push_cmd)
  );

  // Command queue.
  pcpa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .qstat    (qstat)
  );

  // List executor with the next-link memory and result register.
  pcpa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qstat          (qstat),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_alloc_addr (out_alloc_addr),
    .out_status     (out_status),
    .bstat          (bstat)
  );

  // The executor only takes a command when it is idle and the queue holds one.
  `PCPA_ASSERT_IMPL(a_pop_when_idle, q_pop, bstat.idle && !qstat.empty, "pop while busy or empty")
  // An out-of-memory result never carries an address.
  `PCPA_ASSERT_IMPL(a_oom_zero, out_valid && (out_status == STAT_OOM), out_alloc_addr == '0, "OOM with address")
  // With nothing queued or in work, a taken result is not followed by another.
  `PCPA_ASSERT_NEXT(a_no_spurious, out_valid && out_ready && bstat.idle && qstat.empty, !out_valid, "spurious result")
  // While the lists are being rebuilt no result is offered.
  `PCPA_ASSERT_IMPL(a_init_quiet, bstat.in_init, !out_valid, "result during initialize")

endmodule

// ===== tb/sv/per_cpu_page_allocator_tb.sv =====
`timescale 1ns / 1ps

module per_cpu_page_allocator_tb;
  import pcpa_pkg::*;

  // The one action code that the package leaves unnamed.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CPU_IN_W-1:0] cpu;
    logic [ADDR_W-1:0]   page_addr;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   alloc_addr;
    logic [STATUS_W-1:0] status;
  } page_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  in_action = '0;
  logic [CPU_IN_W-1:0]  in_cpu = '0;
  logic [ADDR_W-1:0]    in_page_addr = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_alloc_addr;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  // Shadow of the allocator: registers, free-list heads and next links.
  logic [ADDR_W-1:0] base_reg = BASE_RESET;
  logic [ADDR_W-1:0] top_reg = TOP_RESET;
  logic [LINK_W-1:0] link_mem [NUM_PAGES];
  logic [LINK_W-1:0] head_of [NUM_CPUS];

  page_req_t pending_reqs[$];
  page_rsp_t expected_rsps[$];
  page_req_t cur_req;
  page_rsp_t got_want;

  int n_errors = 0;
  int n_accepted = 0;
  int n_queued = 0;
  int n_checked = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  per_cpu_page_allocator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_cpu         (in_cpu),
    .in_page_addr   (in_page_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_alloc_addr (out_alloc_addr),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // The managed area starts at base rounded up to a whole page.
  function automatic logic [63:0] managed_base();
    return ((64'(base_reg) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES)) * 64'(PAGE_BYTES);
  endfunction

  // Pops one list and returns its old head (page number + 1, zero if empty).
  function automatic logic [LINK_W-1:0] take_head(input int c);
    logic [LINK_W-1:0] h;
    h = head_of[c];
    if (h != 0) head_of[c] = link_mem[h - 1];
    return h;
  endfunction

  // Chains all managed pages in descending order and splits them among the CPUs.
  function automatic void rebuild_lists();
    logic [63:0] pb, npg, q, share0, pos, sz, pg;
    pb = managed_base();
    npg = 0;
    pos = 0;
    if (64'(top_reg) > pb) npg = (64'(top_reg) - pb) / 64'(PAGE_BYTES);
    if (npg > 64'(NUM_PAGES)) npg = 64'(NUM_PAGES);
    q = npg / 64'(NUM_CPUS);
    share0 = q + npg % 64'(NUM_CPUS);
    for (int c = 0; c < NUM_CPUS; c++) begin
      sz = (c == 0) ? share0 : q;
      head_of[c] = '0;
      if (sz != 0) begin
        head_of[c] = LINK_W'(npg - pos);
        for (int k = 0; k < int'(sz); k++) begin
          pg = npg - 1 - (pos + 64'(k));
          link_mem[pg] = (64'(k + 1) < sz) ? LINK_W'(pg) : '0;
        end
        pos = pos + sz;
      end
    end
  endfunction

  // Applies one request to the shadow state and returns the result it must give.
  function automatic page_rsp_t predict_page_op(input page_req_t r);
    page_rsp_t res;
    logic [LINK_W-1:0] h;
    logic [63:0] pb, pa, idx;
    logic bad;
    int c;
    res.alloc_addr = '0;
    res.status = STAT_OK;
    c = int'(r.cpu) % NUM_CPUS;
    case (r.action)
      ACT_ALLOC: begin
        h = take_head(c);
        // Steal from the lowest-numbered other list that has a page.
        for (int o = 0; o < NUM_CPUS; o++) begin
          if (h == 0 && o != c && head_of[o] != 0) h = take_head(o);
        end
        if (h == 0) begin
          res.status = STAT_OOM;
        end else begin
          res.alloc_addr = ADDR_W'(managed_base() + 64'(h - 1) * 64'(PAGE_BYTES));
        end
      end
      ACT_FREE: begin
        pb = managed_base();
        pa = 64'(r.page_addr);
        idx = 0;
        bad = (pa % 64'(PAGE_BYTES) != 0) || pa < 64'(base_reg) || pa >= 64'(top_reg)
              || pa < pb;
        if (!bad) begin
          idx = (pa - pb) / 64'(PAGE_BYTES);
          if (idx >= 64'(NUM_PAGES)) bad = 1'b1;
        end
        if (bad) begin
          res.status = STAT_BAD;
        end else begin
          link_mem[idx] = head_of[c];
          head_of[c] = LINK_W'(idx + 1);
        end
      end
      ACT_INIT: begin
        rebuild_lists();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    n_errors++;
  endtask

  // Request driver: offers queued requests, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(predict_page_op(cur_req));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 3) != 0)) begin
          cur_req = pending_reqs.pop_front();
          in_action <= cur_req.action;
          in_cpu <= cur_req.cpu;
          in_page_addr <= cur_req.page_addr;
          in_valid <= 1'b1;
        end else begin
          if (pending_reqs.size() != 0) tx_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result acceptor: random stalls, plus one long hold-off so the input backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rx_gap <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                  out_alloc_addr, out_status));
      end else begin
        got_want = expected_rsps.pop_front();
        if (out_alloc_addr !== got_want.alloc_addr)
          report_mismatch($sformatf("alloc_addr %h, predicted %h",
                                    out_alloc_addr, got_want.alloc_addr));
        if (out_status !== got_want.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    out_status, got_want.status));
      end
    end
  end

  // Writes both registers back to back; only called while the block is idle.
  task automatic set_config(input logic [ADDR_W-1:0] base_val, input logic [ADDR_W-1:0] top_val);
    cfg_index <= REG_BASE;
    cfg_data <= base_val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_reg = base_val;
    cfg_index <= REG_TOP;
    cfg_data <= top_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    top_reg = top_val;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_req(input logic [ACTION_W-1:0] action, input int cpu,
                           input logic [ADDR_W-1:0] addr);
    page_req_t r;
    r.action = action;
    r.cpu = CPU_IN_W'(cpu);
    r.page_addr = addr;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  // Mostly allocates and frees of pages in the managed area, with some noise.
  task automatic queue_random(input int count, input int init_pct);
    logic [63:0] pb, span;
    page_req_t r;
    int pick;
    pb = managed_base();
    span = 4;
    if (64'(top_reg) > pb) span = (64'(top_reg) - pb) / 64'(PAGE_BYTES);
    if (span > 64'(NUM_PAGES + 2)) span = 64'(NUM_PAGES + 2);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      r.cpu = CPU_IN_W'($urandom_range(0, 7));
      r.page_addr = ADDR_W'({$urandom, $urandom});
      if (pick < init_pct) begin
        r.action = ACT_INIT;
      end else if (pick < 50) begin
        r.action = ACT_ALLOC;
      end else if (pick < 85) begin
        r.action = ACT_FREE;
        r.page_addr = ADDR_W'(pb + 64'($urandom_range(0, int'(span))) * 64'(PAGE_BYTES));
      end else if (pick < 96) begin
        r.action = ACT_FREE;
      end else if (pick < 98) begin
        r.action = ACT_FREE;
        r.page_addr = ADDR_W'(pb + 64'($urandom_range(1, PAGE_BYTES - 1)));
      end else begin
        r.action = ACT_UNUSED;
      end
      pending_reqs.push_back(r);
      n_queued++;
    end
  endtask

  // Every queued request has had its result taken, so nothing is in flight.
  task automatic wait_drained();
    @(posedge clk);
    while (n_checked < n_queued)
      @(posedge clk);
  endtask

  // Test sequence: one phase per register setting.
  initial begin
    for (int c = 0; c < NUM_CPUS; c++) head_of[c] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, before any initialize: empty lists, bad frees, a steal.
    queue_req(ACT_ALLOC, 0, '0);
    queue_req(ACT_UNUSED, 7, '1);
    queue_req(ACT_FREE, 1, 56'h0000_0000_8000_0800);
    queue_req(ACT_FREE, 1, 56'h0000_0000_7FFF_F000);
    queue_req(ACT_FREE, 1, 56'h0000_0000_8800_0000);
    queue_req(ACT_FREE, 7, 56'h0000_0000_8000_0000);
    queue_req(ACT_ALLOC, 0, '0);
    queue_req(ACT_ALLOC, 7, '0);
    wait_drained();

    // Unaligned base and a 37-page area; the long hold-off falls in here.
    set_config(56'h0000_0001_0000_0123, 56'h0000_0001_0002_6064);
    queue_req(ACT_INIT, 0, '0);
    queue_req(ACT_ALLOC, 0, '0);
    queue_req(ACT_ALLOC, 7, '0);
    queue_req(ACT_FREE, 2, 56'h0000_0001_0000_0123);
    queue_req(ACT_FREE, 2, 56'h0000_0001_0000_0000);
    queue_req(ACT_FREE, 5, 56'h0000_0001_0002_6000);
    queue_req(ACT_ALLOC, 5, '0);
    queue_req(ACT_FREE, 3, '0);
    queue_random(300, 3);
    wait_drained();

    // Empty area at address zero.
    set_config('0, '0);
    queue_req(ACT_INIT, 4, '0);
    queue_req(ACT_FREE, 4, '0);
    queue_random(30, 5);
    wait_drained();

    // Both registers at their maximum: the rounded base lies beyond the top.
    set_config('1, '1);
    queue_req(ACT_INIT, 6, '0);
    queue_req(ACT_FREE, 6, 56'hFF_FFFF_FFFF_F000);
    queue_random(30, 5);
    wait_drained();

    // Whole address space: initialize is capped at the page count.
    set_config('0, '1);
    queue_req(ACT_INIT, 0, '0);
    queue_req(ACT_FREE, 1, 56'h0000_0000_07FF_F000);
    queue_req(ACT_FREE, 1, 56'h0000_0000_0800_0000);
    queue_req(ACT_ALLOC, 1, '0);
    queue_random(200, 0);
    wait_drained();

    // Top below base.
    set_config(56'h0000_0000_0001_0000, 56'h0000_0000_0000_8000);
    queue_req(ACT_INIT, 2, '0);
    queue_req(ACT_FREE, 2, 56'h0000_0000_0000_9000);
    queue_random(30, 5);
    wait_drained();

    // Fewer pages than CPUs, run without any idling.
    set_config(56'h0000_0000_0000_5000, 56'h0000_0000_0000_8000);
    quiet = 1'b1;
    queue_random(330, 5);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_rsps.size() != 0) report_mismatch("predicted results never arrived");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
